FILE: sv/rcwm_pkg.sv
// ============================================================================
// rcwm_pkg: shared types and constants of the region checked word memory
// Operation and status codes, configuration register indexes, reset values
// and the command and status groups between the controller and datapath.
// ============================================================================
package rcwm_pkg;

  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 32;
  localparam int LEN_W           = 13;
  localparam int NUM_CFG_REGIONS = 3;
  localparam int CFG_IDX_W       = 3;

  typedef logic [1:0] op_t;

  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_ALLOC = 2'd2;

  typedef logic [3:0] status_t;

  localparam status_t ST_OK             = 4'd0;
  localparam status_t ST_ALLOC_PAST     = 4'd1;
  localparam status_t ST_ALLOC_NONE     = 4'd2;
  localparam status_t ST_READ_DENIED    = 4'd3;
  localparam status_t ST_READ_UNMAPPED  = 4'd4;
  localparam status_t ST_WRITE_DENIED   = 4'd5;
  localparam status_t ST_WRITE_UNMAPPED = 4'd6;
  localparam status_t ST_CROSSES        = 4'd7;
  localparam status_t ST_FULL           = 4'd8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_R0_BASE = 3'd0;
  localparam cfg_idx_t CFG_R0_LEN  = 3'd1;
  localparam cfg_idx_t CFG_R1_BASE = 3'd2;
  localparam cfg_idx_t CFG_R1_LEN  = 3'd3;
  localparam cfg_idx_t CFG_R2_BASE = 3'd4;
  localparam cfg_idx_t CFG_R2_LEN  = 3'd5;
  localparam cfg_idx_t CFG_LOCK    = 3'd6;

  localparam logic [WORD_W-1:0] RST_BASE0 = 32'h0040_0000;
  localparam logic [WORD_W-1:0] RST_BASE1 = 32'h1000_0000;
  localparam logic [WORD_W-1:0] RST_BASE2 = 32'h7FFF_F000;
  localparam logic [LEN_W-1:0]  RST_LEN   = 13'd4096;

  typedef struct packed {
    logic [NUM_CFG_REGIONS-1:0][WORD_W-1:0] base;
    logic [NUM_CFG_REGIONS-1:0][LEN_W-1:0]  len;
    logic                                   lock;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic resolve;
    logic scan_clr;
    logic scan_step;
    logic exec;
    logic clear_step;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic scan_done;
  } stat_t;

endpackage

FILE: sv/rcwm_if.sv
// ============================================================================
// rcwm_if: request and result channels of the region checked word memory
// Valid/ready channels; a word moves at a clock edge with both high.
// ============================================================================
interface rcwm_in_if;
  logic                             valid;
  logic                             ready;
  rcwm_pkg::op_t                    op;
  logic [rcwm_pkg::WORD_W-1:0]      address;
  logic [rcwm_pkg::WORD_W-1:0]      write_word;
  logic [rcwm_pkg::WORD_W-1:0]      span_bytes;

  modport source (output valid, op, address, write_word, span_bytes, input ready);
  modport sink (input valid, op, address, write_word, span_bytes, output ready);
endinterface

interface rcwm_out_if;
  logic                             valid;
  logic                             ready;
  logic [rcwm_pkg::WORD_W-1:0]      read_word;
  rcwm_pkg::status_t                status;

  modport source (output valid, read_word, status, input ready);
  modport sink (input valid, read_word, status, output ready);
endinterface

FILE: sv/rcwm_ram.sv
// ============================================================================
// rcwm_ram: simple dual-port memory
// One write port and one read port; the read data is registered.
// ============================================================================
module rcwm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/rcwm_ctrl.sv
// ============================================================================
// rcwm_ctrl: sequencing controller
// Walks each word through decode, region resolve, for locked reads and writes
// a table scan, execute and result hand-off; zeroes memory after reset.
// ============================================================================
module rcwm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rcwm_pkg::stat_t stat,
  output rcwm_pkg::ctrl_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_DECODE  = 7'b0000100,
    S_RESOLVE = 7'b0001000,
    S_SCAN    = 7'b0010000,
    S_EXEC    = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve  = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = stat.need_scan ? S_SCAN : S_EXEC;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // The result register must be empty or draining this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_capture_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DECODE)
    else $error("accepted word did not enter decode");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLEAR |=> state_r != S_CLEAR)
    else $error("clearing pass restarted outside reset");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result presented without finishing a word");

endmodule

FILE: sv/rcwm_dp.sv
// ============================================================================
// rcwm_dp: datapath of the region checked word memory
// Region compare, allocation table, four byte-lane memory banks and the
// result register.
// ============================================================================
module rcwm_dp #(
  parameter int REGION_BYTES = 4096,
  parameter int NUM_REGIONS  = 3,
  parameter int MAX_ALLOCS   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rcwm_pkg::cfg_t              cfg,
  input  rcwm_pkg::ctrl_t             cmd,
  output rcwm_pkg::stat_t             stat,
  input  rcwm_pkg::op_t               in_op,
  input  logic [rcwm_pkg::WORD_W-1:0] in_address,
  input  logic [rcwm_pkg::WORD_W-1:0] in_write_word,
  input  logic [rcwm_pkg::WORD_W-1:0] in_span_bytes,
  output logic [rcwm_pkg::WORD_W-1:0] out_read_word,
  output rcwm_pkg::status_t           out_status
);

  localparam int WORD_W      = rcwm_pkg::WORD_W;
  localparam int BYTE_W      = rcwm_pkg::BYTE_W;
  localparam int NR          = rcwm_pkg::NUM_CFG_REGIONS;
  localparam int SEL_W       = $clog2(NR);
  localparam int OFF_W       = $clog2(REGION_BYTES);
  localparam int ULEN_W      = $clog2(REGION_BYTES + 1);
  localparam int LCMP_W      = (ULEN_W > rcwm_pkg::LEN_W) ? ULEN_W : rcwm_pkg::LEN_W;
  localparam int TOTAL_BYTES = NUM_REGIONS * REGION_BYTES;
  localparam int PA_W        = $clog2(TOTAL_BYTES);
  localparam int BANK_DEPTH  = (TOTAL_BYTES + 3) / 4;
  localparam int WA_W        = $clog2(BANK_DEPTH);
  localparam int IDX_W       = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int CNT_W       = $clog2(MAX_ALLOCS + 1);

  // Latched request.
  rcwm_pkg::op_t     op_r;
  logic [WORD_W-1:0] addr_r, wdata_r, span_r;

  // Decode stage: one compare set per region.
  logic [WORD_W:0]                   aend;
  logic [NR-1:0][LCMP_W-1:0]         len_ext;
  logic [NR-1:0][WORD_W:0]           rend;
  logic [NR-1:0][WORD_W-1:0]         diff;
  logic [NR-1:0]                     hit_nxt, aok_nxt;
  logic [NR-1:0][OFF_W-1:0]          off_nxt;
  logic [NR-1:0][ULEN_W-1:0]         used_nxt;
  logic [NR-1:0]                     hit_r, aok_r;
  logic [NR-1:0][OFF_W-1:0]          off_r;
  logic [NR-1:0][ULEN_W-1:0]         used_r;

  // Resolve stage.
  logic [SEL_W-1:0]  sel;
  logic [OFF_W-1:0]  off_sel;
  logic [ULEN_W-1:0] used_sel;
  logic [PA_W-1:0]   rstart, p_nxt, p_r;
  logic              crosses_nxt;
  logic              mapped_r, crosses_r, apast_r;

  // Allocation table scan.
  logic [CNT_W-1:0]  alloc_cnt_r, scan_idx_r;
  logic              scan_live, cmp_v_r, found_r, match;
  logic [WORD_W-1:0] tab_start_q, tab_len_q;
  logic              tab_we;

  // Execute and result.
  rcwm_pkg::status_t st_nxt, st_r, out_status_r;
  logic              acc_ok, alloc_ok, rd_ok_r;
  logic [WORD_W-1:0] assembled, out_word_r;

  // Byte lanes.
  logic [1:0]                rot;
  logic                      bank_we, bank_re;
  logic [3:0][WA_W-1:0]      lane_addr;
  logic [3:0][1:0]           lane_k;
  logic [3:0][BYTE_W-1:0]    lane_wd, lane_q;
  logic [WA_W-1:0]           clr_idx_r;

  always_comb begin
    aend = {1'b0, addr_r} + {1'b0, span_r};
    for (int r = 0; r < NR; r++) begin
      len_ext[r]  = LCMP_W'(cfg.len[r]);
      // A length above the storage acts as the storage size.
      used_nxt[r] = (len_ext[r] > LCMP_W'(REGION_BYTES)) ? ULEN_W'(REGION_BYTES)
                                                         : ULEN_W'(cfg.len[r]);
      rend[r]     = {1'b0, cfg.base[r]} + (WORD_W + 1)'(used_nxt[r]);
      diff[r]     = addr_r - cfg.base[r];
      off_nxt[r]  = diff[r][OFF_W-1:0];
      hit_nxt[r]  = (r < NUM_REGIONS) && (addr_r >= cfg.base[r]) &&
                    ({1'b0, addr_r} < rend[r]);
      aok_nxt[r]  = aend < rend[r];
    end
  end

  always_comb begin
    sel = '0;
    // Lowest-numbered matching region wins.
    for (int r = NR - 1; r >= 0; r--) begin
      if (hit_r[r]) begin
        sel = SEL_W'(r);
      end
    end
    off_sel     = off_r[sel];
    used_sel    = used_r[sel];
    crosses_nxt = ({1'b0, ULEN_W'(off_sel)} + (ULEN_W + 1)'(4)) > {1'b0, used_sel};
    rstart      = PA_W'(REGION_BYTES * int'(sel));
    p_nxt       = rstart + PA_W'(off_sel);
  end

  assign scan_live = scan_idx_r < alloc_cnt_r;
  assign match     = cmp_v_r && (addr_r >= tab_start_q) &&
                     ({1'b0, addr_r} < ({1'b0, tab_start_q} + {1'b0, tab_len_q}));

  always_comb begin
    st_nxt   = rcwm_pkg::ST_OK;
    acc_ok   = 1'b0;
    alloc_ok = 1'b0;
    case (op_r)
      rcwm_pkg::OP_READ, rcwm_pkg::OP_WRITE: begin
        if (cfg.lock && !found_r) begin
          st_nxt = (op_r == rcwm_pkg::OP_WRITE) ? rcwm_pkg::ST_WRITE_DENIED
                                                : rcwm_pkg::ST_READ_DENIED;
        end else if (!mapped_r) begin
          st_nxt = (op_r == rcwm_pkg::OP_WRITE) ? rcwm_pkg::ST_WRITE_UNMAPPED
                                                : rcwm_pkg::ST_READ_UNMAPPED;
        end else if (crosses_r) begin
          st_nxt = rcwm_pkg::ST_CROSSES;
        end else begin
          acc_ok = 1'b1;
        end
      end
      rcwm_pkg::OP_ALLOC: begin
        if (!mapped_r) begin
          st_nxt = rcwm_pkg::ST_ALLOC_NONE;
        end else if (apast_r) begin
          st_nxt = rcwm_pkg::ST_ALLOC_PAST;
        end else if (alloc_cnt_r == CNT_W'(MAX_ALLOCS)) begin
          st_nxt = rcwm_pkg::ST_FULL;
        end else begin
          alloc_ok = 1'b1;
        end
      end
      default: begin
        st_nxt = rcwm_pkg::ST_OK;
      end
    endcase
  end

  assign tab_we  = cmd.exec && alloc_ok;
  assign rot     = p_r[1:0];
  assign bank_we = cmd.clear_step || (cmd.exec && acc_ok && (op_r == rcwm_pkg::OP_WRITE));
  assign bank_re = cmd.exec && acc_ok && (op_r == rcwm_pkg::OP_READ);

  // Byte k of the word sits in lane (rot + k) mod 4; lanes below rot use the
  // next row.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_k[l]    = 2'(l) - rot;
      lane_addr[l] = cmd.clear_step ? clr_idx_r
                                    : WA_W'(p_r[PA_W-1:2]) + WA_W'(2'(l) < rot);
      lane_wd[l]   = cmd.clear_step ? '0 : wdata_r[{lane_k[l], 3'b000} +: BYTE_W];
    end
    for (int k = 0; k < 4; k++) begin
      assembled[k*BYTE_W +: BYTE_W] = lane_q[2'(rot + 2'(k))];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    rcwm_ram #(
      .DATA_W (BYTE_W),
      .DEPTH  (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we),
      .waddr (lane_addr[l]),
      .wdata (lane_wd[l]),
      .re    (bank_re),
      .raddr (lane_addr[l]),
      .rdata (lane_q[l])
    );
  end

  rcwm_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (MAX_ALLOCS)
  ) u_tab_start (
    .clk   (clk),
    .we    (tab_we),
    .waddr (alloc_cnt_r[IDX_W-1:0]),
    .wdata (addr_r),
    .re    (cmd.scan_step && scan_live),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (tab_start_q)
  );

  rcwm_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (MAX_ALLOCS)
  ) u_tab_len (
    .clk   (clk),
    .we    (tab_we),
    .waddr (alloc_cnt_r[IDX_W-1:0]),
    .wdata (span_r),
    .re    (cmd.scan_step && scan_live),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (tab_len_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      addr_r  <= in_address;
      wdata_r <= in_write_word;
      span_r  <= in_span_bytes;
    end
    if (cmd.decode) begin
      hit_r  <= hit_nxt;
      aok_r  <= aok_nxt;
      off_r  <= off_nxt;
      used_r <= used_nxt;
    end
    if (cmd.resolve) begin
      mapped_r  <= |hit_r;
      crosses_r <= crosses_nxt;
      apast_r   <= !aok_r[sel];
      p_r       <= p_nxt;
    end
    if (cmd.exec) begin
      st_r    <= st_nxt;
      rd_ok_r <= bank_re;
    end
    if (cmd.load_out) begin
      out_word_r   <= rd_ok_r ? assembled : '0;
      out_status_r <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_cnt_r <= '0;
      clr_idx_r   <= '0;
      scan_idx_r  <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (tab_we) begin
        alloc_cnt_r <= alloc_cnt_r + CNT_W'(1);
      end
      if (cmd.clear_step) begin
        clr_idx_r <= clr_idx_r + WA_W'(1);
      end
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
        cmp_v_r    <= 1'b0;
        found_r    <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_v_r <= scan_live;
        if (scan_live) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
        if (match) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  assign stat.clear_last = (clr_idx_r == WA_W'(BANK_DEPTH - 1));
  assign stat.need_scan  = cfg.lock &&
                           ((op_r == rcwm_pkg::OP_READ) || (op_r == rcwm_pkg::OP_WRITE));
  assign stat.scan_done  = found_r || (!scan_live && !cmp_v_r);

  assign out_read_word = out_word_r;
  assign out_status    = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_cnt_r <= CNT_W'(MAX_ALLOCS))
    else $error("allocation count beyond table depth");

  a_access_in_storage: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && acc_ok |-> (32'(p_r) + 32'd3 < 32'(TOTAL_BYTES)))
    else $error("word access runs past the byte storage");

  a_found_by_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(found_r) |-> $past(cmd.scan_step))
    else $error("allocation hit raised outside a table scan");

endmodule

FILE: sv/region_checked_word_memory_top.sv
// ============================================================================
// region_checked_word_memory_top: byte memory of three checked address regions
// Serves read-word, write-word and allocate requests with region and
// allocation checks; configured through a plain register write port.
// ============================================================================
// Usage:
//   in_chan carries one request word (op, address, write_word, span_bytes);
//   out_chan returns one result word (read_word, status) for every request, in
//   order. cfg_we/cfg_index/cfg_wdata write the region bases and lengths and
//   the lock bit; write them only while no request is in flight.
// Sequencing:
//   A request is taken only once the previous one has reached the output
//   register, so words are processed one at a time. Reads and writes made
//   while the lock is on also scan the allocation table one entry per cycle
//   through its single read port, stopping early when an entry matches.
// Reset:
//   rst_n is synchronous. Afterwards the byte storage is zeroed one row of
//   four bytes per cycle over all NUM_REGIONS * REGION_BYTES bytes, and
//   in_chan.ready stays low until that pass ends.
//   Configuration writes are taken during the pass.
// Stalls:
//   The result sits in an output register; while it waits for out_chan.ready
//   the next request is still accepted and processed up to its hand-off.
// ============================================================================
module region_checked_word_memory_top #(
  parameter int REGION_BYTES = 4096,
  parameter int NUM_REGIONS  = 3,
  parameter int MAX_ALLOCS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rcwm_in_if.sink                        in_chan,
  rcwm_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  rcwm_pkg::cfg_idx_t             cfg_index,
  input  logic [rcwm_pkg::WORD_W-1:0]    cfg_wdata
);

  localparam int NR = rcwm_pkg::NUM_CFG_REGIONS;

  // Configuration register file. Lengths keep all 13 written bits; the
  // datapath clamps them to the storage size when it uses them.
  logic [NR-1:0][rcwm_pkg::WORD_W-1:0] base_r;
  logic [NR-1:0][rcwm_pkg::LEN_W-1:0]  len_r;
  logic                                lock_r;

  rcwm_pkg::cfg_t  cfg;
  rcwm_pkg::ctrl_t cmd;
  rcwm_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0] <= rcwm_pkg::RST_BASE0;
      base_r[1] <= rcwm_pkg::RST_BASE1;
      base_r[2] <= rcwm_pkg::RST_BASE2;
      len_r[0]  <= rcwm_pkg::RST_LEN;
      len_r[1]  <= rcwm_pkg::RST_LEN;
      len_r[2]  <= rcwm_pkg::RST_LEN;
      lock_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rcwm_pkg::CFG_R0_BASE: base_r[0] <= cfg_wdata;
        rcwm_pkg::CFG_R0_LEN:  len_r[0]  <= cfg_wdata[rcwm_pkg::LEN_W-1:0];
        rcwm_pkg::CFG_R1_BASE: base_r[1] <= cfg_wdata;
        rcwm_pkg::CFG_R1_LEN:  len_r[1]  <= cfg_wdata[rcwm_pkg::LEN_W-1:0];
        rcwm_pkg::CFG_R2_BASE: base_r[2] <= cfg_wdata;
        rcwm_pkg::CFG_R2_LEN:  len_r[2]  <= cfg_wdata[rcwm_pkg::LEN_W-1:0];
        rcwm_pkg::CFG_LOCK:    lock_r    <= cfg_wdata[0];
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

  assign cfg.base = base_r;
  assign cfg.len  = len_r;
  assign cfg.lock = lock_r;

  // The controller owns the handshakes and sequencing; the datapath holds
  // the request, the checks, the table, the byte banks and the result word.
  rcwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rcwm_dp #(
    .REGION_BYTES (REGION_BYTES),
    .NUM_REGIONS  (NUM_REGIONS),
    .MAX_ALLOCS   (MAX_ALLOCS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_chan.op),
    .in_address    (in_chan.address),
    .in_write_word (in_chan.write_word),
    .in_span_bytes (in_chan.span_bytes),
    .out_read_word (out_chan.read_word),
    .out_status    (out_chan.status)
  );

endmodule
